[src/cmc_pkg.sv]
`default_nettype none

package cmc_pkg;

   // Map and position geometry
   localparam int MAP_ENTRIES   = 1024;
   localparam int POSITION_BITS = 16;
   localparam int IDX_W         = $clog2(MAP_ENTRIES);
   localparam int PROD_W        = POSITION_BITS + IDX_W + 1;

   // Fixed field widths of the ports
   localparam int Q16_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int RD_IDX_W = 10;
   localparam int REP_IDX_W = 10;
   localparam int TICK_W   = 16;
   localparam int GAP_W    = 10;
   localparam int GAP_MAX  = 1023;

   // Step counter holds 2*gap + 2*entries + 1
   localparam int STEP_W = $clog2(2 * GAP_MAX + 2 * MAP_ENTRIES + 2);

   // One map step of travel, rounded half up, and the rounding offset of the index
   localparam logic [POSITION_BITS-1:0] POS_STEP =
      POSITION_BITS'(((1 << POSITION_BITS) + MAP_ENTRIES / 2) / MAP_ENTRIES);
   localparam logic [PROD_W-1:0] IDX_HALF = PROD_W'(1 << (POSITION_BITS - 1));

   localparam logic [TICK_W-1:0] TICK_DIVIDE_RESET = TICK_W'(500);
   localparam logic [GAP_W-1:0]  GAP_STEPS_RESET   = GAP_W'(100);

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_READ  = 2'd2,
      ACT_END   = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      CSR_TICK_DIVIDE = 1'b0,
      CSR_GAP_STEPS   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_INDEX,
      ST_ACCESS,
      ST_MERGE
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick_divide;
      logic [GAP_W-1:0]  gap_steps;
   } cfg_type;

   typedef struct packed {
      logic [Q16_W-1:0]     position_command;
      logic                 report_valid;
      logic [REP_IDX_W-1:0] report_index;
      logic [SAMPLE_W-1:0]  report_value;
      logic                 finished;
      logic                 map_valid;
      logic [SAMPLE_W-1:0]  read_value;
   } rsp_type;

   // Scale a Q0.16 fraction to the internal position width
   function automatic logic [POSITION_BITS-1:0] pos_from_q16(input logic [Q16_W-1:0] v);
      logic [Q16_W+POSITION_BITS-1:0] t;
      t = {v, {POSITION_BITS{1'b0}}} >> Q16_W;
      return t[POSITION_BITS-1:0];
   endfunction

   // Scale the internal position to a Q0.16 fraction
   function automatic logic [Q16_W-1:0] pos_to_q16(input logic [POSITION_BITS-1:0] p);
      logic [Q16_W+POSITION_BITS-1:0] t;
      t = {p, {Q16_W{1'b0}}} >> POSITION_BITS;
      return t[Q16_W-1:0];
   endfunction

endpackage

`default_nettype wire

[src/cogging_map_calibration_sequencer_top.sv]
`default_nettype none

// Cogging map calibration sequencer.
// Command channel: drive req_* and raise start; a transaction is taken at a
// rising edge with start high and busy low. Actions: tick, start, read map
// entry, end. Each transaction gives exactly one result, shown on the rsp_*
// ports for one cycle with rsp_strobe high; the receiver cannot stall it.
// Result timing, counted from the accepting edge:
//   tick with no recording step, end with a valid map: next cycle (busy stays low)
//   read: via ST_READ_WAIT; step CW: via ST_INDEX, ST_ACCESS; CCW: + ST_MERGE
//   start, and end with an invalid map: after a full ST_CLEAR pass
// The map sits in one single-port RAM with a registered read; a CCW step is a
// read, then an averaged write back in ST_MERGE. Start, and end with an invalid
// map, sweep zeros through all 1024 entries, one per cycle, with busy high.
// Reset: synchronous, active high. After reset the block runs the same
// clearing pass with busy high and no result; configuration writes on the
// csr_ channel are taken at any time (csr_ready stays high) and reset
// to tick_divide 500 and gap_steps 100.
module cogging_map_calibration_sequencer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire cmc_pkg::action_type              req_action,
   input  wire logic [cmc_pkg::SAMPLE_W-1:0]     req_current_sample,
   input  wire logic [cmc_pkg::Q16_W-1:0]        req_start_position,
   input  wire logic [cmc_pkg::RD_IDX_W-1:0]     req_read_index,
   output logic                                  rsp_strobe,
   output logic [cmc_pkg::Q16_W-1:0]             rsp_position_command,
   output logic                                  rsp_report_valid,
   output logic [cmc_pkg::REP_IDX_W-1:0]         rsp_report_index,
   output logic [cmc_pkg::SAMPLE_W-1:0]          rsp_report_value,
   output logic                                  rsp_finished,
   output logic                                  rsp_map_valid,
   output logic [cmc_pkg::SAMPLE_W-1:0]          rsp_read_value,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire cmc_pkg::csr_index_type           csr_index,
   input  wire logic [cmc_pkg::TICK_W-1:0]       csr_data
);

   import cmc_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   rsp_type              rsp;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_addr;
   logic [SAMPLE_W-1:0]  mem_wdata;
   logic [SAMPLE_W-1:0]  mem_rdata;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICK_DIVIDE: cfg_in.tick_divide = csr_data;
            CSR_GAP_STEPS:   cfg_in.gap_steps   = csr_data[GAP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_divide <= TICK_DIVIDE_RESET;
         cfg_ff.gap_steps   <= GAP_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cmc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .action         (req_action),
      .current_sample (req_current_sample),
      .start_position (req_start_position),
      .read_index     (req_read_index),
      .cfg            (cfg_ff),
      .mem_we         (mem_we),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .mem_rdata      (mem_rdata),
      .rsp_strobe     (rsp_strobe),
      .rsp            (rsp)
   );

   cmc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAP_ENTRIES)
   ) u_map_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_position_command = rsp.position_command;
   assign rsp_report_valid     = rsp.report_valid;
   assign rsp_report_index     = rsp.report_index;
   assign rsp_report_value     = rsp.report_value;
   assign rsp_finished         = rsp.finished;
   assign rsp_map_valid        = rsp.map_valid;
   assign rsp_read_value       = rsp.read_value;

endmodule

`default_nettype wire

[src/cmc_ram.sv]
`default_nettype none

module cmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, register the read every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/cmc_ctrl.sv]
`default_nettype none

module cmc_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire cmc_pkg::action_type              action,
   input  wire logic [cmc_pkg::SAMPLE_W-1:0]     current_sample,
   input  wire logic [cmc_pkg::Q16_W-1:0]        start_position,
   input  wire logic [cmc_pkg::RD_IDX_W-1:0]     read_index,
   input  wire cmc_pkg::cfg_type                 cfg,
   output logic                                  mem_we,
   output logic [cmc_pkg::IDX_W-1:0]             mem_addr,
   output logic [cmc_pkg::SAMPLE_W-1:0]          mem_wdata,
   input  wire logic [cmc_pkg::SAMPLE_W-1:0]     mem_rdata,
   output logic                                  rsp_strobe,
   output cmc_pkg::rsp_type                      rsp
);

   import cmc_pkg::*;

   state_type               state_ff, state_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [TICK_W-1:0]       tc_ff, tc_in;
   logic [STEP_W-1:0]       sc_ff, sc_in;
   logic                    run_ff, run_in;
   logic                    valid_ff, valid_in;
   logic [IDX_W-1:0]        clr_cnt_ff, clr_cnt_in;
   logic                    clr_rsp_ff, clr_rsp_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic                    ccw_ff, ccw_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    rsp_strobe_ff, rsp_go;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic [STEP_W-1:0]       gap_ext, bound_cw_gap, bound_cw_rec, bound_ccw_gap, bound_ccw_rec;
   logic [POSITION_BITS-1:0] pos_cw, pos_ccw;
   logic [PROD_W-1:0]       prod;
   logic [IDX_W:0]          idx_full;
   logic [IDX_W+RD_IDX_W-1:0] ri_wide;
   logic [IDX_W+REP_IDX_W-1:0] rep_idx_wide;
   logic [SAMPLE_W:0]       sum, sum_adj;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Phase boundaries of the run
   assign gap_ext       = STEP_W'(cfg.gap_steps);
   assign bound_cw_gap  = gap_ext;
   assign bound_cw_rec  = gap_ext + STEP_W'(MAP_ENTRIES);
   assign bound_ccw_gap = bound_cw_rec + gap_ext;
   assign bound_ccw_rec = bound_ccw_gap + STEP_W'(MAP_ENTRIES);

   // One map step either way, wrapping modulo a turn
   assign pos_cw  = pos_ff + POS_STEP;
   assign pos_ccw = pos_ff - POS_STEP;

   // Nearest map index of the current position
   assign prod     = PROD_W'(pos_ff) * PROD_W'(MAP_ENTRIES) + IDX_HALF;
   assign idx_full = prod[PROD_W-1:POSITION_BITS];

   assign ri_wide      = (IDX_W + RD_IDX_W)'(read_index);
   assign rep_idx_wide = (IDX_W + REP_IDX_W)'(idx_ff);

   // Average of stored entry and sample, truncated toward zero
   assign sum     = {mem_rdata[SAMPLE_W-1], mem_rdata} + {sample_ff[SAMPLE_W-1], sample_ff};
   assign sum_adj = sum + (SAMPLE_W + 1)'(sum[SAMPLE_W]);

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      tc_in      = tc_ff;
      sc_in      = sc_ff;
      run_in     = run_ff;
      valid_in   = valid_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      rd_ok_in   = rd_ok_ff;
      ccw_in     = ccw_ff;
      sample_in  = sample_ff;
      idx_in     = idx_ff;
      mem_we     = 1'b0;
      mem_addr   = clr_cnt_ff;
      mem_wdata  = '0;
      rsp_go     = 1'b0;
      rsp_in     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep zeros through the map
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(MAP_ENTRIES - 1)) begin
               clr_cnt_in = '0;
               clr_rsp_in = 1'b0;
               rsp_go     = clr_rsp_ff;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_START: begin
                     pos_in     = pos_from_q16(start_position);
                     valid_in   = 1'b0;
                     tc_in      = '0;
                     sc_in      = '0;
                     run_in     = 1'b1;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  ACT_READ: begin
                     mem_addr = ri_wide[IDX_W-1:0];
                     rd_ok_in = (ri_wide < (IDX_W + RD_IDX_W)'(MAP_ENTRIES));
                     state_in = ST_READ_WAIT;
                  end
                  ACT_END: begin
                     run_in = 1'b0;
                     if (!valid_ff) begin
                        clr_cnt_in = '0;
                        clr_rsp_in = 1'b1;
                        state_in   = ST_CLEAR;
                     end else begin
                        rsp_go = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     if (!run_ff) begin
                        rsp_go = 1'b1;
                     end else begin
                        tc_in = tc_ff + TICK_W'(1);
                        if (tc_in >= cfg.tick_divide) begin
                           tc_in = '0;
                           sc_in = sc_ff + STEP_W'(1);
                           priority if (sc_in <= bound_cw_gap) begin
                              pos_in = pos_cw;
                              rsp_go = 1'b1;
                           end else if (sc_in <= bound_cw_rec) begin
                              ccw_in    = 1'b0;
                              sample_in = current_sample;
                              state_in  = ST_INDEX;
                           end else if (sc_in <= bound_ccw_gap) begin
                              pos_in = pos_ccw;
                              rsp_go = 1'b1;
                           end else if (sc_in <= bound_ccw_rec) begin
                              ccw_in    = 1'b1;
                              sample_in = current_sample;
                              state_in  = ST_INDEX;
                           end else begin
                              rsp_in.finished = 1'b1;
                              valid_in        = 1'b1;
                              run_in          = 1'b0;
                              rsp_go          = 1'b1;
                           end
                        end else begin
                           rsp_go = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_in.read_value = rd_ok_ff ? mem_rdata : '0;
            rsp_go            = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_INDEX: begin
            // Register the index, folding a full turn back to zero
            idx_in   = (idx_full >= (IDX_W + 1)'(MAP_ENTRIES)) ? '0 : idx_full[IDX_W-1:0];
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            mem_addr = idx_ff;
            if (!ccw_ff) begin
               mem_we              = 1'b1;
               mem_wdata           = sample_ff;
               rsp_in.report_valid = 1'b1;
               rsp_in.report_index = rep_idx_wide[REP_IDX_W-1:0];
               rsp_in.report_value = sample_ff;
               pos_in              = pos_cw;
               rsp_go              = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            mem_addr            = idx_ff;
            mem_we              = 1'b1;
            mem_wdata           = sum_adj[SAMPLE_W:1];
            rsp_in.report_valid = 1'b1;
            rsp_in.report_index = rep_idx_wide[REP_IDX_W-1:0];
            rsp_in.report_value = sample_ff;
            pos_in              = pos_ccw;
            rsp_go              = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.position_command = pos_to_q16(pos_in);
      rsp_in.map_valid        = valid_in;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pos_ff        <= '0;
         tc_ff         <= '0;
         sc_ff         <= '0;
         run_ff        <= 1'b0;
         valid_ff      <= 1'b0;
         clr_cnt_ff    <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         tc_ff         <= tc_in;
         sc_ff         <= sc_in;
         run_ff        <= run_in;
         valid_ff      <= valid_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_strobe_ff <= rsp_go;
      end
   end

   // Hold payload of the transaction in flight and of the result
   always_ff @(posedge clock) begin
      rd_ok_ff  <= rd_ok_in;
      ccw_ff    <= ccw_in;
      sample_ff <= sample_in;
      idx_ff    <= idx_in;
      if (rsp_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

`ifndef NO_ASSERTIONS
   a_fin_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.finished |-> rsp_ff.map_valid)
      else $error("finish reported without map valid");

   a_fin_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_ff.finished && rsp_ff.report_valid))
      else $error("finish and sample report in one result");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (action == ACT_START) |=> (state_ff == ST_CLEAR) && !valid_ff)
      else $error("start did not begin a clearing pass");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("map written while idle");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff || $past(accept))
      else $error("result repeated without a transaction");
`endif

endmodule

`default_nettype wire
